### hdl/kspt_pkg.sv
// Shared types, constants and a key function for the keyed sorted price table.
package kspt_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_BYTES_DEF = 32;
	localparam int WORDS         = 4;
	localparam int KEY_W         = 64 * WORDS;
	localparam int PRICE_W       = 32;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_CHANGE = 3'd2,
		OP_QLOW   = 3'd3,
		OP_QHIGH  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} fsm_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic                      rm_en;    // close the gap at the first match
		logic                      ins_en;   // open a slot and insert
		logic [KEY_W-1:0]          key;
		logic signed [PRICE_W-1:0] price;
	} cell_cmd_t;

	// Zero every byte after the first zero byte and beyond key_bytes.
	function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw,
			input int key_bytes);
		logic [KEY_W-1:0] res;
		logic ended;
		res = '0;
		ended = 1'b0;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (b >= key_bytes || raw[8*b +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				res[8*b +: 8] = raw[8*b +: 8];
		end
		return res;
	endfunction

endpackage

### hdl/kspt_cell.sv
// One table slot: holds an entry and shifts it to a neighbor on insert or removal.
module kspt_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kspt_pkg::cell_cmd_t               cmd,
	input  logic                              prev_valid,
	input  logic [kspt_pkg::KEY_W-1:0]        prev_key,
	input  logic signed [kspt_pkg::PRICE_W-1:0] prev_price,
	input  logic                              prev_ins_here, // insert point is at or left
	input  logic                              prev_match_seen,
	input  logic                              next_valid,
	input  logic [kspt_pkg::KEY_W-1:0]        next_key,
	input  logic signed [kspt_pkg::PRICE_W-1:0] next_price,
	output logic                              valid_q,
	output logic [kspt_pkg::KEY_W-1:0]        key_q,
	output logic signed [kspt_pkg::PRICE_W-1:0] price_q,
	output logic                              ins_here,
	output logic                              match_seen
);
	import kspt_pkg::*;

	logic ge;
	logic match;

	// First slot whose price is >= new price (or first empty) is the insert point.
	assign ge         = !valid_q || (price_q >= cmd.price);
	assign ins_here   = prev_ins_here || ge;
	assign match      = valid_q && (key_q == cmd.key);
	assign match_seen = prev_match_seen || match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rm_en && match_seen) begin
			valid_q <= next_valid;
		end else if (cmd.ins_en && ins_here) begin
			valid_q <= prev_ins_here ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rm_en && match_seen) begin
			key_q   <= next_key;
			price_q <= next_price;
		end else if (cmd.ins_en && ins_here) begin
			key_q   <= prev_ins_here ? prev_key : cmd.key;
			price_q <= prev_ins_here ? prev_price : cmd.price;
		end
	end
endmodule

### hdl/kspt_ctrl.sv
// Operation sequencer: issues remove and insert steps to the cell row and sets the result status.
module kspt_ctrl #(
	parameter int CNT_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 opcode,
	input  logic                       out_stall,
	output logic                       out_valid,
	input  logic                       any_match,
	input  logic [CNT_W-1:0]           count,
	input  logic                       full,
	output logic                       latch_in,
	output logic                       rm_en,
	output logic                       ins_en,
	output logic                       load_out,
	output logic [1:0]                 status_nxt,
	output logic                       show_low,
	output logic                       show_found
);
	import kspt_pkg::*;

	fsm_t state_q, state_nxt;
	logic [2:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= 3'd0;
		end else begin
			state_q <= state_nxt;
			if (latch_in)
				op_q <= opcode;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_EXEC;
			S_EXEC: state_nxt = S_OUT;
			S_OUT:  if (!out_stall) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != S_IDLE);
		latch_in   = (state_q == S_IDLE) && in_valid;
		out_valid  = (state_q == S_OUT);
		rm_en      = 1'b0;
		ins_en     = 1'b0;
		load_out   = 1'b0;
		status_nxt = ST_OK;
		show_low   = (op_q == OP_QLOW);
		show_found = 1'b0;
		if (state_q == S_EXEC) begin
			load_out = 1'b1;
			case (op_q) inside
				OP_INSERT: begin
					if (full) status_nxt = ST_FULL;
					else ins_en = 1'b1;
				end
				OP_DELETE, OP_CHANGE: begin
					if (!any_match) status_nxt = ST_NOTFOUND;
					else rm_en = 1'b1;
				end
				OP_QLOW, OP_QHIGH: begin
					if (count == '0) status_nxt = ST_EMPTY;
					else show_found = 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

### hdl/keyed_sorted_price_table_unit.sv
// Top level of the keyed sorted price table: control, cell row and result register.
//  channel | signals                                   | dir
//  in      | in_valid, in_stall, opcode, key_word_0..3, | into block
//          | price_in                                  |
//  out     | out_valid, out_stall, status, found_word_* | out of block
// A transaction passes the accept, execute and result states; for a price change
// whose name is found, the row removes the entry in the execute state and
// reinserts it in the next cycle. All cells compare in parallel.
// Reset clears the count, the cell valid bits and the sequencer.
// A stalled result holds the block; no new transaction is taken meanwhile.
module keyed_sorted_price_table_unit #(
	parameter int CAPACITY  = kspt_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES = kspt_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [63:0] key_word_0,
	input  logic [63:0] key_word_1,
	input  logic [63:0] key_word_2,
	input  logic [63:0] key_word_3,
	input  logic signed [31:0] price_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] found_word_0,
	output logic [63:0] found_word_1,
	output logic [63:0] found_word_2,
	output logic [63:0] found_word_3
);
	import kspt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0]          key_q;
	logic signed [PRICE_W-1:0] price_q;
	logic [2:0]                op_q;
	logic                      reins_q;
	logic [CNT_W-1:0]          count_q;
	logic                      latch_in, rm_en, ins_en, load_out, show_low, show_found;
	logic [1:0]                status_nxt;
	logic                      c_in_stall, c_out_valid;
	cell_cmd_t                 cmd;

	logic                      v   [CAPACITY];
	logic [KEY_W-1:0]          k   [CAPACITY];
	logic signed [PRICE_W-1:0] p   [CAPACITY];
	logic                      ih  [CAPACITY];
	logic                      ms  [CAPACITY];

	logic [1:0]  status_q;
	logic [KEY_W-1:0] found_q;
	logic [CNT_W-1:0] last_idx;
	logic        hold_q;

	always_ff @(posedge clk) begin
		if (latch_in) begin
			key_q   <= canon_key({key_word_3, key_word_2, key_word_1, key_word_0}, KEY_BYTES);
			price_q <= price_in;
			op_q    <= opcode;
		end
	end

	kspt_ctrl #(.CNT_W(CNT_W)) u_ctrl (
		.clk, .arst_n, .in_valid,
		.in_stall(c_in_stall), .opcode,
		.out_stall(out_stall || reins_q), .out_valid(c_out_valid),
		.any_match(ms[CAPACITY-1]), .count(count_q), .full(count_q == CNT_W'(CAPACITY)),
		.latch_in, .rm_en, .ins_en, .load_out, .status_nxt, .show_low, .show_found
	);

	// Price change: remove in the execute cycle, reinsert in the following one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reins_q <= 1'b0;
			count_q <= '0;
			hold_q  <= 1'b0;
		end else begin
			reins_q <= rm_en && (op_q == OP_CHANGE);
			hold_q  <= reins_q;
			if (cmd.ins_en)
				count_q <= count_q + 1'b1;
			else if (cmd.rm_en)
				count_q <= count_q - 1'b1;
		end
	end

	assign in_stall  = c_in_stall;
	assign out_valid = c_out_valid && !reins_q;

	always_comb begin
		cmd.rm_en  = rm_en;
		cmd.ins_en = ins_en || reins_q;
		cmd.key    = key_q;
		cmd.price  = price_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			kspt_cell u_cell (
				.clk, .arst_n, .cmd,
				.prev_valid     (gi == 0 ? 1'b0 : v[(gi == 0) ? 0 : gi-1]),
				.prev_key       (gi == 0 ? '0 : k[(gi == 0) ? 0 : gi-1]),
				.prev_price     (gi == 0 ? '0 : p[(gi == 0) ? 0 : gi-1]),
				.prev_ins_here  (gi == 0 ? 1'b0 : ih[(gi == 0) ? 0 : gi-1]),
				.prev_match_seen(gi == 0 ? 1'b0 : ms[(gi == 0) ? 0 : gi-1]),
				.next_valid     (gi == CAPACITY-1 ? 1'b0 : v[(gi == CAPACITY-1) ? gi : gi+1]),
				.next_key       (gi == CAPACITY-1 ? '0 : k[(gi == CAPACITY-1) ? gi : gi+1]),
				.next_price     (gi == CAPACITY-1 ? '0 : p[(gi == CAPACITY-1) ? gi : gi+1]),
				.valid_q(v[gi]), .key_q(k[gi]), .price_q(p[gi]),
				.ins_here(ih[gi]), .match_seen(ms[gi])
			);
		end
	endgenerate

	assign last_idx = count_q - 1'b1;

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_nxt;
			if (!show_found)
				found_q <= '0;
			else if (show_low)
				found_q <= k[0];
			else
				found_q <= k[last_idx[$clog2(CAPACITY)-1:0]];
		end
	end

	assign status       = status_q;
	assign found_word_0 = found_q[63:0];
	assign found_word_1 = found_q[127:64];
	assign found_word_2 = found_q[191:128];
	assign found_word_3 = found_q[255:192];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> v[0]) else $error("nonempty table with empty head slot");
	a_reins_follows: assert property (@(posedge clk) disable iff (!arst_n)
		reins_q |-> $past(rm_en)) else $error("reinsert without prior removal");
	a_hold_unused: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> !reins_q) else $error("back to back reinserts");
endmodule

### verif/tb_keyed_sorted_price_table_unit.sv
// Testbench for keyed_sorted_price_table_unit: directed and random tests against a behavioral table.
module tb_keyed_sorted_price_table_unit;
	import kspt_pkg::*;

	localparam int CAP = 64;
	localparam int KBYTES = 32;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  st;
		logic [63:0] w0, w1, w2, w3;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = OP_INSERT;
	logic [63:0] key_word_0 = '0, key_word_1 = '0, key_word_2 = '0, key_word_3 = '0;
	logic signed [31:0] price_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [63:0] found_word_0, found_word_1, found_word_2, found_word_3;

	keyed_sorted_price_table_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// behavioral copy of the table
	logic [KEY_W-1:0] tbl_key[$];
	logic signed [31:0] tbl_price[$];
	table_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	logic [KEY_W-1:0] name_pool[8];
	int burst_len = 0;
	int stall_mode = 0;

	function automatic logic [KEY_W-1:0] clean_name(logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] res;
		logic ended;
		res = '0;
		ended = 1'b0;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (b >= KBYTES || raw[8*b +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				res[8*b +: 8] = raw[8*b +: 8];
		end
		return res;
	endfunction

	task automatic place_sorted(logic [KEY_W-1:0] k, logic signed [31:0] p);
		int pos;
		pos = 0;
		while (pos < tbl_price.size() && tbl_price[pos] < p)
			pos++;
		tbl_key.insert(pos, k);
		tbl_price.insert(pos, p);
	endtask

	function automatic int locate(logic [KEY_W-1:0] k);
		foreach (tbl_key[i])
			if (tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	task automatic predict_table(logic [2:0] op, logic [KEY_W-1:0] raw,
			logic signed [31:0] p);
		table_result_t r;
		logic [KEY_W-1:0] k, f;
		int pos;
		r = '0;
		f = '0;
		k = clean_name(raw);
		case (op) inside
			OP_INSERT: begin
				if (tbl_key.size() >= CAP)
					r.st = ST_FULL;
				else
					place_sorted(k, p);
			end
			OP_DELETE, OP_CHANGE: begin
				pos = locate(k);
				if (pos < 0)
					r.st = ST_NOTFOUND;
				else begin
					tbl_key.delete(pos);
					tbl_price.delete(pos);
					if (op == OP_CHANGE)
						place_sorted(k, p);
				end
			end
			OP_QLOW, OP_QHIGH: begin
				if (tbl_key.size() == 0)
					r.st = ST_EMPTY;
				else
					f = (op == OP_QLOW) ? tbl_key[0] : tbl_key[tbl_key.size()-1];
			end
			default: ;
		endcase
		{r.w3, r.w2, r.w1, r.w0} = f;
		pending_results.push_back(r);
	endtask

	// sender in bursts with random gaps
	task automatic send_item(logic [2:0] op, logic [KEY_W-1:0] raw, logic signed [31:0] p);
		if (burst_len == 0) begin
			burst_len = $urandom_range(1, 12);
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		burst_len--;
		in_valid = 1'b1;
		opcode <= op;
		{key_word_3, key_word_2, key_word_1, key_word_0} <= raw;
		price_in <= p;
		predict_table(op, raw, p);
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_mode == 0)
			out_stall <= 1'b0;
		else if (stall_mode == 1)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= (($urandom_range(0, 15) < 10) && (cycles % 23 < 15));
	end

	always @(posedge clk) begin
		table_result_t exp_r;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status exp %0d act %0d", exp_r.st, status);
					errors++;
				end
				if (found_word_0 !== exp_r.w0) begin
					$error("found_word_0 exp %h act %h", exp_r.w0, found_word_0);
					errors++;
				end
				if (found_word_1 !== exp_r.w1) begin
					$error("found_word_1 exp %h act %h", exp_r.w1, found_word_1);
					errors++;
				end
				if (found_word_2 !== exp_r.w2) begin
					$error("found_word_2 exp %h act %h", exp_r.w2, found_word_2);
					errors++;
				end
				if (found_word_3 !== exp_r.w3) begin
					$error("found_word_3 exp %h act %h", exp_r.w3, found_word_3);
					errors++;
				end
			end
		end
	end

	function automatic logic [KEY_W-1:0] random_raw();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] random_name();
		logic [KEY_W-1:0] k;
		int len;
		k = random_raw();
		len = $urandom_range(1, 32);
		for (int b = len; b < 32; b++)
			k[8*b +: 8] = ($urandom_range(0, 1)) ? 8'h00 : k[8*b +: 8];
		if (k[7:0] == 8'h00)
			k[7:0] = 8'h41;
		return k;
	endfunction

	function automatic logic signed [31:0] random_price();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7) - 4;
			1: return $urandom;
			2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	task automatic test_empty_queries();
		send_item(OP_QLOW, '0, '0);
		send_item(OP_QHIGH, '1, '1);
		send_item(OP_DELETE, 256'h41, '0);
		send_item(OP_CHANGE, 256'h41, 32'sd5);
	endtask

	task automatic test_directed_ops();
		send_item(OP_INSERT, {8{32'hffffffff}}, 32'sh7fffffff);
		send_item(OP_INSERT, 256'h42, 32'sh80000000);
		send_item(OP_INSERT, 256'h43, 32'sd0);
		send_item(OP_INSERT, 256'h0000_4300_0000_0000_0043, 32'sd0); // bytes after zero cleared
		send_item(OP_QLOW, '0, '0);
		send_item(OP_QHIGH, '0, '0);
		send_item(OP_CHANGE, 256'h43, 32'sh7fffffff);
		send_item(OP_QHIGH, '0, '0);
		send_item(OP_DELETE, {8{32'hffffffff}}, '0);
		send_item(OP_DELETE, 256'h99, '0);
		send_item(3'd5, random_raw(), random_price());
		send_item(3'd7, '1, '1);
		send_item(OP_QLOW, '0, '0);
	endtask

	task automatic test_full_table();
		while (tbl_key.size() < CAP)
			send_item(OP_INSERT, random_name(), random_price());
		send_item(OP_INSERT, 256'h44, 32'sd1);
		send_item(OP_QHIGH, '0, '0);
		while (tbl_key.size() > 0)
			send_item(OP_DELETE, tbl_key[$urandom_range(0, tbl_key.size()-1)], '0);
		send_item(OP_QLOW, '0, '0);
	endtask

	task automatic test_random_mix(int n);
		logic [2:0] op;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < 8; i++)
			name_pool[i] = random_name();
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				stall_mode = $urandom_range(0, 2);
			op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(0, 4));
			case ($urandom_range(0, 5))
				0: k = random_raw();
				1, 2: k = name_pool[$urandom_range(0, 7)];
				default: k = (tbl_key.size() > 0) ?
					tbl_key[$urandom_range(0, tbl_key.size()-1)] : random_name();
			endcase
			send_item(op, k, random_price());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_queries();
		test_directed_ops();
		test_full_table();
		test_random_mix(1000);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
